### design/julian_day_to_calendar_macros.svh
// ----------------------------------------------------------------------------
// Julian day to calendar assertion macros
// Shared property forms for the checker, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef JULIAN_DAY_TO_CALENDAR_MACROS_SVH
`define JULIAN_DAY_TO_CALENDAR_MACROS_SVH

// Check cons in the same cycle as ante.
`define JDC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define JDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/jdc_pkg.sv
// ----------------------------------------------------------------------------
// jdc_pkg
// Types and constants for the Julian day number to calendar date pipeline.
// Constant divides use exact reciprocals: for x < 2**N and 2**(L-1) < D <= 2**L,
// floor(x / D) == (x * ceil(2**(N+L) / D)) >> (N+L).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jdc_pkg;

  localparam int unsigned DN_W = 23;

  // Calendar constants
  localparam int unsigned ERA_SWITCH  = 2299160;
  localparam int unsigned GREG_OFS    = 68569;
  localparam int unsigned GREG_CYCLE  = 146097;
  localparam int unsigned YQ_SCALE    = 4000;
  localparam int unsigned YQ_DIV      = 1461001;
  localparam int unsigned LEAP_CYCLE  = 1461;
  localparam int unsigned MONTH_SCALE = 80;
  localparam int unsigned MONTH_DIV   = 2447;
  localparam int unsigned JUL_OFS     = 1402;
  localparam int unsigned JUL_EPOCH   = 4716;
  localparam int unsigned YEAR_DAYS   = 365;
  localparam int unsigned CENTURY     = 100;

  // Gregorian century: x = 4a < 2**26, D = 146097 (L = 18)
  localparam int unsigned CEN_SH = 44;
  localparam logic [26:0] CEN_M =
    27'(((64'd1 << CEN_SH) + 64'(GREG_CYCLE) - 64'd1) / 64'(GREG_CYCLE));

  // Julian four-year cycle: x = b - 1 < 2**24, D = 1461 (L = 11)
  localparam int unsigned JUL_SH = 35;
  localparam logic [24:0] JUL_M =
    25'(((64'd1 << JUL_SH) + 64'(LEAP_CYCLE) - 64'd1) / 64'(LEAP_CYCLE));

  // Gregorian year of century: x = 4000 * (a + 1) < 2**28, D = 1461001 (L = 21)
  // The 4000 scale is folded into the reciprocal.
  localparam int unsigned YQ_SH = 49;
  localparam logic [40:0] YQ_M =
    41'(64'(YQ_SCALE) *
        (((64'd1 << YQ_SH) + 64'(YQ_DIV) - 64'd1) / 64'(YQ_DIV)));

  // Julian year in cycle: x < 2**11, D = 365 (L = 9)
  localparam int unsigned YD_SH = 20;
  localparam logic [11:0] YD_M =
    12'(((64'd1 << YD_SH) + 64'(YEAR_DAYS) - 64'd1) / 64'(YEAR_DAYS));

  // Month index: x = 80 * c < 2**17, D = 2447 (L = 12), 80 folded in
  localparam int unsigned MQ_SH = 29;
  localparam logic [24:0] MQ_M =
    25'(64'(MONTH_SCALE) *
        (((64'd1 << MQ_SH) + 64'(MONTH_DIV) - 64'd1) / 64'(MONTH_DIV)));

  // Century test: x < 2**15, D = 100 (L = 7)
  localparam int unsigned C100_SH = 22;
  localparam logic [15:0] C100_M =
    16'(((64'd1 << C100_SH) + 64'(CENTURY) - 64'd1) / 64'(CENTURY));

  // Day offset of each month index: floor(2447 * mq / 80)
  localparam logic [8:0] MONTH_START [16] = '{
    9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd152, 9'd183, 9'd214,
    9'd244, 9'd275, 9'd305, 9'd336, 9'd367, 9'd397, 9'd428, 9'd458
  };

  // Day within the shifted year and the year before the month carry
  typedef struct packed {
    logic [9:0]         doy;
    logic signed [15:0] base;
    logic               jul;
  } doy_t;

  typedef struct packed {
    logic signed [15:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
  } date_t;

endpackage

### design/jdc_era.sv
// ----------------------------------------------------------------------------
// jdc_era
// Four-stage front end: runs the Gregorian and Julian era formulas side by
// side and selects the day within the shifted year and the base year.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jdc_era
  import jdc_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [DN_W-1:0] day_number,
  output logic            out_valid,
  input  logic            out_stall,
  output doy_t            out_doy
);

  localparam int unsigned NS = 4;

  logic [NS-1:0] v;
  logic [NS-1:0] v_in;
  logic [NS:0]   go;

  // Stage 1 registers
  logic [23:0] s1_a;
  logic [23:0] s1_bm;
  logic [52:0] s1_pc;
  logic [48:0] s1_pj;
  logic        s1_greg;

  // Stage 2 registers
  logic [7:0]  s2_cen;
  logic [15:0] s2_a2;
  logic [12:0] s2_cenj;
  logic [10:0] s2_aj;
  logic        s2_greg;

  // Stage 3 registers
  logic [56:0] s3_py;
  logic [22:0] s3_pyj;
  logic        s3_wrap;
  logic [15:0] s3_a2;
  logic [10:0] s3_aj;
  logic [7:0]  s3_cen;
  logic [12:0] s3_cenj;
  logic        s3_greg;

  // Combinational stage logic
  logic [23:0]        a_sum;
  logic [23:0]        bm_sum;
  logic [7:0]         cen;
  logic [25:0]        cyc_days;
  logic [12:0]        cenj;
  logic [6:0]         yq;
  logic [9:0]         doy_greg;
  logic signed [16:0] base_greg;
  logic [2:0]         qj;
  logic [1:0]         yqj;
  logic [9:0]         doy_jul;
  logic signed [16:0] base_jul;

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    go[NS] = !out_stall;
    for (int k = NS - 1; k >= 0; k--) begin
      go[k] = !v[k] || go[k+1];
    end
  end

  assign v_in      = {v[NS-2:0], in_valid};
  assign in_stall  = !go[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (go[k]) begin
          v[k] <= v_in[k];
        end
      end
    end
  end

  // Stage 1: offset the day number and start both cycle divides
  assign a_sum  = 24'(day_number) + 24'(GREG_OFS);
  assign bm_sum = 24'(day_number) + 24'(JUL_OFS - 1);

  always_ff @(posedge clk) begin
    if (go[0]) begin
      s1_a    <= a_sum;
      s1_bm   <= bm_sum;
      s1_pc   <= 53'({a_sum, 2'b00}) * 53'(CEN_M);
      s1_pj   <= 49'(bm_sum) * 49'(JUL_M);
      s1_greg <= day_number > DN_W'(ERA_SWITCH);
    end
  end

  // Stage 2: take the cycle counts and the day within each cycle
  assign cen      = 8'(s1_pc >> CEN_SH);
  assign cyc_days = 26'(cen) * 26'(GREG_CYCLE) + 26'd3;
  assign cenj     = 13'(s1_pj >> JUL_SH);

  always_ff @(posedge clk) begin
    if (go[1]) begin
      s2_cen  <= cen;
      s2_a2   <= 16'(s1_a - 24'(cyc_days >> 2));
      s2_cenj <= cenj;
      s2_aj   <= 11'(s1_bm + 24'd1 - 24'(cenj * 13'(LEAP_CYCLE)));
      s2_greg <= s1_greg;
    end
  end

  // Stage 3: start the year-in-cycle divides
  always_ff @(posedge clk) begin
    if (go[2]) begin
      s3_py   <= (57'(s2_a2) + 57'd1) * 57'(YQ_M);
      s3_pyj  <= 23'(s2_aj - 11'd1) * 23'(YD_M);
      s3_wrap <= s2_aj == 11'(LEAP_CYCLE);
      s3_a2   <= s2_a2;
      s3_aj   <= s2_aj;
      s3_cen  <= s2_cen;
      s3_cenj <= s2_cenj;
      s3_greg <= s2_greg;
    end
  end

  // Stage 4: day within the March-based year and base year for each era
  assign yq        = 7'(s3_py >> YQ_SH);
  assign doy_greg  = 10'(17'(s3_a2) - 17'((18'(yq) * 18'(LEAP_CYCLE)) >> 2) + 17'd31);
  assign base_greg = $signed(17'(s3_cen) * 17'(CENTURY)) - 17'sd4900 + $signed(17'(yq));

  assign qj       = 3'(s3_pyj >> YD_SH);
  assign yqj      = 2'(qj - {2'b00, s3_wrap});
  assign doy_jul  = 10'(12'(s3_aj) - 12'(11'(yqj) * 11'(YEAR_DAYS)) + 12'd30);
  assign base_jul = $signed(17'(s3_cenj) * 17'd4) + $signed(17'(yqj))
                  - $signed(17'(JUL_EPOCH));

  always_ff @(posedge clk) begin
    if (go[3]) begin
      out_doy.doy  <= s3_greg ? doy_greg : doy_jul;
      out_doy.base <= s3_greg ? 16'(base_greg) : 16'(base_jul);
      out_doy.jul  <= !s3_greg;
    end
  end

endmodule

### design/jdc_month.sv
// ----------------------------------------------------------------------------
// jdc_month
// Two-stage month split: divides the day within the year into month and day,
// carries January and February into the next year, skips year zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jdc_month
  import jdc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  doy_t  in_doy,
  output logic  out_valid,
  input  logic  out_stall,
  output date_t out_date
);

  localparam int unsigned NS = 2;

  logic [NS-1:0] v;
  logic [NS-1:0] v_in;
  logic [NS:0]   go;

  logic [34:0] m1_pm;
  doy_t        m1_doy;

  logic [3:0]         mq;
  logic               carry;
  logic signed [15:0] yr_sum;

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    go[NS] = !out_stall;
    for (int k = NS - 1; k >= 0; k--) begin
      go[k] = !v[k] || go[k+1];
    end
  end

  assign v_in      = {v[NS-2:0], in_valid};
  assign in_stall  = !go[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (go[k]) begin
          v[k] <= v_in[k];
        end
      end
    end
  end

  // Stage 1: start the month divide
  always_ff @(posedge clk) begin
    if (go[0]) begin
      m1_pm  <= 35'(in_doy.doy) * 35'(MQ_M);
      m1_doy <= in_doy;
    end
  end

  // Stage 2: month, day and year with the January/February carry
  assign mq     = 4'(m1_pm >> MQ_SH);
  assign carry  = mq >= 4'd11;
  assign yr_sum = m1_doy.base + $signed({15'd0, carry});

  always_ff @(posedge clk) begin
    if (go[1]) begin
      out_date.day   <= 5'(m1_doy.doy - 10'(MONTH_START[mq]));
      out_date.month <= carry ? (mq - 4'd10) : (mq + 4'd2);
      out_date.year  <= (m1_doy.jul && (yr_sum <= 16'sd0)) ? (yr_sum - 16'sd1) : yr_sum;
    end
  end

endmodule

### design/jdc_fix.sv
// ----------------------------------------------------------------------------
// jdc_fix
// Two-stage century check: moves 29 February of a century year after 1599
// that is not a multiple of 400 to 1 March, and holds the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jdc_fix
  import jdc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  date_t              in_date,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] year,
  output logic [3:0]         month,
  output logic [4:0]         day
);

  localparam int unsigned NS = 2;

  logic [NS-1:0] v;
  logic [NS-1:0] v_in;
  logic [NS:0]   go;

  logic [30:0] f1_p;
  date_t       f1_date;

  logic [8:0] q;
  logic       whole;
  logic       fix;

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    go[NS] = !out_stall;
    for (int k = NS - 1; k >= 0; k--) begin
      go[k] = !v[k] || go[k+1];
    end
  end

  assign v_in      = {v[NS-2:0], in_valid};
  assign in_stall  = !go[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (go[k]) begin
          v[k] <= v_in[k];
        end
      end
    end
  end

  // Stage 1: start the divide of the year by 100
  always_ff @(posedge clk) begin
    if (go[0]) begin
      f1_p    <= 31'(in_date.year[14:0]) * 31'(C100_M);
      f1_date <= in_date;
    end
  end

  // Stage 2: a century year has no remainder; a multiple of 400 has q % 4 == 0
  assign q     = 9'(f1_p >> C100_SH);
  assign whole = 15'(15'(q) * 15'(CENTURY)) == f1_date.year[14:0];
  assign fix   = (f1_date.year > 16'sd1599) && whole && (q[1:0] != 2'b00)
              && (f1_date.month == 4'd2) && (f1_date.day == 5'd29);

  always_ff @(posedge clk) begin
    if (go[1]) begin
      year  <= f1_date.year;
      month <= fix ? 4'd3 : f1_date.month;
      day   <= fix ? 5'd1 : f1_date.day;
    end
  end

endmodule

### design/julian_day_to_calendar.sv
// ----------------------------------------------------------------------------
// julian_day_to_calendar: Julian day number to calendar year, month and day
// Throughput: one transaction per cycle while out_stall is low; each constant
// divide is a reciprocal multiply registered in its own stage. Reset clears
// only the stage valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module julian_day_to_calendar
  import jdc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [DN_W-1:0]    day_number,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] year,
  output logic [3:0]         month,
  output logic [4:0]         day
);

  logic  era_valid;
  logic  era_stall;
  doy_t  era_doy;
  logic  mon_valid;
  logic  mon_stall;
  date_t mon_date;

  // Era formulas
  jdc_era u_era (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .day_number (day_number),
    .out_valid  (era_valid),
    .out_stall  (era_stall),
    .out_doy    (era_doy)
  );

  // Month and day split
  jdc_month u_month (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (era_valid),
    .in_stall  (era_stall),
    .in_doy    (era_doy),
    .out_valid (mon_valid),
    .out_stall (mon_stall),
    .out_date  (mon_date)
  );

  // Century leap check and output register
  jdc_fix u_fix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mon_valid),
    .in_stall  (mon_stall),
    .in_date   (mon_date),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .year      (year),
    .month     (month),
    .day       (day)
  );

endmodule

### design/jdc_checker.sv
// ----------------------------------------------------------------------------
// jdc_checker
// Port-level checks on the converter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "julian_day_to_calendar_macros.svh"

module jdc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] year,
  input logic [3:0]         month,
  input logic [4:0]         day
);

  // A stalled result holds
  `JDC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(year) && $stable(month) && $stable(day), "stalled result changed")

  // Month stays in range
  `JDC_ASSERT_SAME(a_month_range, out_valid, (month >= 4'd1) && (month <= 4'd12), "month out of range")

  // Day stays in range
  `JDC_ASSERT_SAME(a_day_range, out_valid, (day >= 5'd1) && (day <= 5'd31), "day out of range")

  // There is no year zero
  `JDC_ASSERT_SAME(a_no_year_zero, out_valid, year != 16'sd0, "year zero produced")

  // An empty output register lets the whole pipeline advance
  `JDC_ASSERT_SAME(a_empty_no_stall, !out_valid && in_valid, !in_stall, "input stalled with empty output")

endmodule

bind julian_day_to_calendar jdc_checker u_jdc_checker (.*);
